>>> hw/rtl/ncg_pkg.sv
`default_nettype none

package ncg_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int MAX_PICK  = 16;

    localparam int SET_W   = 6;
    localparam int PICK_W  = 5;
    localparam int POS_W   = 5;
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 30;
    localparam int SEL_W   = 6;
    localparam int MASK_W  = 32;
    localparam int CFG_W   = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SEL_W-1:0]   SEL_NONE  = {SEL_W{1'b1}};

    // request codes, anything else is a plain query
    localparam logic [1:0] REQ_RESTART = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;

    // configuration register indexes
    localparam logic CFG_SET_SIZE  = 1'b0;
    localparam logic CFG_PICK_SIZE = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/next_combination_generator_core.sv
// Lexicographic k-combination generator. Write set_size (n, index 0) and
// pick_size (k, index 1) over the configuration channel, then send words with
// req_type 0 (restart), 1 (advance) or anything else (query only); every input
// word returns exactly one result word with the running count, the exhausted
// and error flags, the item held at position query_value and the membership of
// item query_value. One shared compare/increment unit walks the positions
// under a small sequencer, one position per cycle, and the block takes no new
// word until the current result is taken. A restart, a query or a blocked
// advance passes through the mask state straight to its result. An advance
// scans from position k-1 down to the first position j that can move, then
// refills positions j+1..k-1, with k up to 16; when the scan finds no such
// position, the advance is reported as exhausted.
`default_nettype none

module next_combination_generator_core (
    input  wire                          aclk,
    input  wire                          aresetn,
    // configuration
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire                          cfg_index,
    input  wire  [ncg_pkg::CFG_W-1:0]    cfg_data,
    // request words
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [1:0]                   s_req_type,
    input  wire  [4:0]                   s_query_value,
    // result words
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [ncg_pkg::COUNT_W-1:0]  m_combo_count,
    output logic                         m_exhausted,
    output logic                         m_config_error,
    output logic signed [ncg_pkg::SEL_W-1:0] m_selected_index,
    output logic                         m_item_selected,
    output logic [ncg_pkg::MASK_W-1:0]   m_selection_mask
);
    import ncg_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_FILL = 5'b00100,
        ST_MASK = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [SET_W-1:0]        set_size_reg;
    logic [PICK_W-1:0]       pick_size_reg;
    logic [POS_W-1:0]        pos_reg [MAX_PICK];
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic                    err_reg, err_next;
    logic                    fail_reg, fail_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [4:0]              q_reg;
    logic                    exh_reg;
    logic [SEL_W-1:0]        sel_reg;
    logic                    member_reg;
    logic [MASK_W-1:0]       mask_reg;

    logic                    in_accept;
    logic                    sizes_ok;
    logic                    pos_clear;
    logic                    pos_we;
    logic [POS_W-1:0]        pos_wdata;
    logic [IDX_W-1:0]        src_idx;
    logic [POS_W-1:0]        inc_val;
    logic                    can_move;
    logic [IDX_W:0]          idx_plus;
    logic                    more_fill;
    logic [PICK_W-1:0]       kl;
    logic [MASK_W-1:0]       mask_calc;
    logic [SEL_W-1:0]        sel_calc;
    logic [COUNT_W-1:0]      count_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign in_accept = s_valid && s_ready;

    assign sizes_ok = ({1'b0, pick_size_reg} <= set_size_reg)
                   && (set_size_reg <= SET_W'(MAX_ITEMS))
                   && (pick_size_reg <= PICK_W'(MAX_PICK));

    // shared unit: one increment and one movability compare
    assign src_idx  = (state_reg == ST_FILL) ? idx_reg - 1'b1 : idx_reg;
    assign inc_val  = pos_reg[src_idx] + 1'b1;
    assign can_move = ({2'b00, pos_reg[idx_reg]} + {2'b00, pick_size_reg})
                    < ({1'b0, set_size_reg} + {3'b000, idx_reg});
    assign idx_plus  = {1'b0, idx_reg} + 1'b1;
    assign more_fill = idx_plus < pick_size_reg;
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    assign kl = (pick_size_reg > PICK_W'(MAX_PICK)) ? PICK_W'(MAX_PICK) : pick_size_reg;

    always_comb begin
        mask_calc = '0;
        for (int j = 0; j < MAX_PICK; j++) begin
            if (PICK_W'(j) < kl) begin
                mask_calc[pos_reg[j]] = 1'b1;
            end
        end
    end

    always_comb begin
        if (q_reg < kl) begin
            sel_calc = {1'b0, pos_reg[q_reg[IDX_W-1:0]]};
        end else begin
            sel_calc = SEL_NONE;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        err_next   = err_reg;
        fail_next  = fail_reg;
        idx_next   = idx_reg;
        pos_clear  = 1'b0;
        pos_we     = 1'b0;
        pos_wdata  = inc_val;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    fail_next  = 1'b0;
                    state_next = ST_MASK;
                    priority if (s_req_type == REQ_RESTART) begin
                        if (sizes_ok) begin
                            err_next   = 1'b0;
                            count_next = '0;
                            pos_clear  = 1'b1;
                        end else begin
                            err_next = 1'b1;
                        end
                    end else if (s_req_type == REQ_ADVANCE) begin
                        if (err_reg || !sizes_ok || pick_size_reg == '0) begin
                            fail_next = 1'b1;
                        end else begin
                            idx_next   = IDX_W'(pick_size_reg - 1'b1);
                            state_next = ST_SCAN;
                        end
                    end else begin
                        // plain query, state untouched
                    end
                end
            end
            ST_SCAN: begin
                if (can_move) begin
                    pos_we = 1'b1;
                    if (more_fill) begin
                        idx_next   = idx_plus[IDX_W-1:0];
                        state_next = ST_FILL;
                    end else begin
                        count_next = count_inc;
                        state_next = ST_MASK;
                    end
                end else if (idx_reg == '0) begin
                    fail_next  = 1'b1;
                    state_next = ST_MASK;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_FILL: begin
                pos_we = 1'b1;
                if (more_fill) begin
                    idx_next = idx_plus[IDX_W-1:0];
                end else begin
                    count_next = count_inc;
                    state_next = ST_MASK;
                end
            end
            ST_MASK: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            set_size_reg  <= '0;
            pick_size_reg <= '0;
            count_reg     <= '0;
            err_reg       <= 1'b0;
            fail_reg      <= 1'b0;
            idx_reg       <= '0;
            for (int j = 0; j < MAX_PICK; j++) begin
                pos_reg[j] <= POS_W'(j);
            end
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            fail_reg  <= fail_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_SET_SIZE:  set_size_reg  <= cfg_data;
                    CFG_PICK_SIZE: pick_size_reg <= cfg_data[PICK_W-1:0];
                    default: ;
                endcase
            end
            if (pos_clear) begin
                for (int j = 0; j < MAX_PICK; j++) begin
                    pos_reg[j] <= POS_W'(j);
                end
            end else if (pos_we) begin
                pos_reg[idx_reg] <= pos_wdata;
            end
        end
    end

    // result word payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            q_reg <= s_query_value;
        end
        if (state_reg == ST_MASK) begin
            exh_reg    <= fail_reg || err_reg || (pick_size_reg == '0);
            sel_reg    <= sel_calc;
            member_reg <= mask_calc[q_reg];
            mask_reg   <= mask_calc;
        end
    end

    assign m_combo_count    = count_reg;
    assign m_exhausted      = exh_reg;
    assign m_config_error   = err_reg;
    assign m_selected_index = sel_reg;
    assign m_item_selected  = member_reg;
    assign m_selection_mask = mask_reg;

    // the count only steps by one or restarts at zero
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1) || (count_reg == '0))
        else $error("count moved by more than one");

    // an error always reports exhausted
    a_err_exh: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_config_error) |-> m_exhausted)
        else $error("error word not flagged exhausted");

    // membership agrees with the mask
    a_member_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item_selected == m_selection_mask[q_reg]))
        else $error("membership and mask disagree");

    // positions only change while an advance or restart is at work
    a_pos_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> $stable(pos_reg[0]) && $stable(count_reg))
        else $error("state changed while result word waits");

endmodule

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

module tb;
    import ncg_pkg::*;

    // request codes that the block treats as a plain query
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               exhausted;
        logic               cfg_err;
        logic [SEL_W-1:0]   sel;
        logic               member;
        logic [MASK_W-1:0]  mask;
    } combo_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_req_type;
    logic [4:0]            s_query_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [COUNT_W-1:0]    m_combo_count;
    logic                  m_exhausted;
    logic                  m_config_error;
    logic signed [SEL_W-1:0] m_selected_index;
    logic                  m_item_selected;
    logic [MASK_W-1:0]     m_selection_mask;

    // shadow of the generator state
    logic [POS_W-1:0]   combo_pos [MAX_PICK];
    logic [COUNT_W-1:0] combo_total;
    bit                 size_error;
    logic [SET_W-1:0]   set_n;
    logic [PICK_W-1:0]  pick_k;

    combo_result_t pending_results [$];
    int  failures;
    int  words_sent;
    bit  steady;
    int  ready_hold;

    next_combination_generator_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_query_value    (s_query_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_combo_count    (m_combo_count),
        .m_exhausted      (m_exhausted),
        .m_config_error   (m_config_error),
        .m_selected_index (m_selected_index),
        .m_item_selected  (m_item_selected),
        .m_selection_mask (m_selection_mask)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

    // mostly short gaps, a few long ones, none while steady
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic combo_result_t step_generator(input logic [1:0] req,
                                                     input logic [4:0] q);
        combo_result_t r;
        int  n, k, kl, j, m;
        bit  sizes_ok, moved;
        n = int'(set_n);
        k = int'(pick_k);
        sizes_ok = (k <= n) && (n <= MAX_ITEMS) && (k <= MAX_PICK);
        moved = 1'b0;
        r.exhausted = 1'b0;
        if (req == REQ_RESTART) begin
            if (!sizes_ok) begin
                size_error = 1'b1;
            end else begin
                size_error = 1'b0;
                for (j = 0; j < MAX_PICK; j++)
                    combo_pos[j] = POS_W'(j);
                combo_total = '0;
            end
        end else if (req == REQ_ADVANCE) begin
            if (size_error || !sizes_ok || k == 0) begin
                r.exhausted = 1'b1;
            end else begin
                // rightmost position that can still move, then refill to its right
                for (j = k - 1; j >= 0 && !moved; j--) begin
                    if (combo_pos[j] + k < n + j) begin
                        combo_pos[j] = combo_pos[j] + 1'b1;
                        for (m = j + 1; m < k; m++)
                            combo_pos[m] = combo_pos[m-1] + 1'b1;
                        moved = 1'b1;
                    end
                end
                if (!moved)
                    r.exhausted = 1'b1;
                else if (combo_total != COUNT_MAX)
                    combo_total = combo_total + 1'b1;
            end
        end
        if (size_error || k == 0)
            r.exhausted = 1'b1;
        kl = (k < MAX_PICK) ? k : MAX_PICK;
        r.sel = (q < kl) ? SEL_W'(combo_pos[q]) : SEL_NONE;
        r.member = 1'b0;
        r.mask = '0;
        for (j = 0; j < kl; j++) begin
            if (combo_pos[j] == q)
                r.member = 1'b1;
            r.mask[combo_pos[j]] = 1'b1;
        end
        r.count = combo_total;
        r.cfg_err = size_error;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        combo_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word expected none actual count %0h", $time,
                         m_combo_count);
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("combo_count", 32'(want.count), 32'(m_combo_count));
                check_field("exhausted", 32'(want.exhausted), 32'(m_exhausted));
                check_field("config_error", 32'(want.cfg_err), 32'(m_config_error));
                check_field("selected_index", 32'(want.sel),
                            32'($unsigned(m_selected_index)));
                check_field("item_selected", 32'(want.member), 32'(m_item_selected));
                check_field("selection_mask", want.mask, m_selection_mask);
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        int g;
        if (aresetn) begin
            if (ready_hold > 0) begin
                ready_hold--;
                m_ready <= 1'b0;
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    ready_hold = g - 1;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_word(input logic [1:0] req, input logic [4:0] q);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_query_value <= q;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(step_generator(req, q));
        words_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SET_SIZE)
            set_n = val;
        else
            pick_k = val[PICK_W-1:0];
        @(posedge aclk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k);
        settle();
        set_reg(CFG_SET_SIZE, n);
        set_reg(CFG_PICK_SIZE, k);
    endtask

    // registers still at reset: nothing picked
    task automatic test_empty_pick();
        send_word(REQ_QUERY, 5'd0);
        send_word(REQ_ADVANCE, 5'd31);
        send_word(REQ_SPARE, 5'd31);
        configure(6'd0, 6'd0);
        send_word(REQ_RESTART, 5'd0);
    endtask

    // every 3-subset of 5 items, then one advance past the end
    task automatic test_small_walk();
        int i;
        configure(6'd5, 6'd3);
        send_word(REQ_RESTART, 5'd2);
        for (i = 0; i < 10; i++)
            send_word(REQ_ADVANCE, 5'(i % 5));
    endtask

    task automatic test_bad_sizes();
        configure(6'd3, 6'd4);
        send_word(REQ_RESTART, 5'd1);
        send_word(REQ_ADVANCE, 5'd0);
        send_word(REQ_QUERY, 5'd3);
        // set size beyond the item limit
        configure(6'd63, 6'd2);
        send_word(REQ_RESTART, 5'd1);
    endtask

    task automatic test_wide_pick();
        configure(6'd32, 6'd16);
        send_word(REQ_RESTART, 5'd15);
        send_word(REQ_ADVANCE, 5'd31);
        send_word(REQ_QUERY, 5'd16);
        send_word(REQ_SPARE, 5'd30);
        // pick above the limit without a restart: lookup clamps to 16 positions
        settle();
        set_reg(CFG_PICK_SIZE, 6'd20);
        send_word(REQ_QUERY, 5'd15);
        send_word(REQ_ADVANCE, 5'd0);
        settle();
        set_reg(CFG_PICK_SIZE, 6'h3F);
        send_word(REQ_QUERY, 5'd31);
    endtask

    task automatic test_random_walks();
        int i, run, phase_len;
        logic [CFG_W-1:0] n, k;
        while (words_sent < 1200) begin
            case ($urandom_range(0, 9))
                0: begin n = 6'd32; k = 6'd16; end
                1: begin n = CFG_W'($urandom()); k = CFG_W'($urandom()); end
                2: begin
                    n = CFG_W'($urandom_range(11, 32));
                    k = CFG_W'($urandom_range(0, 3));
                end
                3: begin
                    k = CFG_W'($urandom_range(12, 16));
                    n = CFG_W'(k + $urandom_range(0, 1));
                end
                default: begin
                    n = CFG_W'($urandom_range(0, 9));
                    k = CFG_W'($urandom_range(0, n + 1));
                end
            endcase
            k[5] = 1'($urandom_range(0, 1));
            settle();
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    set_reg(CFG_SET_SIZE, n);
                else
                    set_reg(CFG_PICK_SIZE, k);
            end else begin
                set_reg(CFG_SET_SIZE, n);
                set_reg(CFG_PICK_SIZE, k);
            end
            steady = ($urandom_range(0, 7) == 0);
            phase_len = $urandom_range(30, 80);
            i = 0;
            while (i < phase_len) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_word(REQ_RESTART, 5'($urandom_range(0, 31)));
                    run = $urandom_range(1, 40);
                    i += run + 1;
                    repeat (run) begin
                        if ($urandom_range(0, 4) == 0)
                            send_word(REQ_QUERY, 5'($urandom_range(0, 31)));
                        else
                            send_word(REQ_ADVANCE, 5'($urandom_range(0, 31)));
                    end
                end else begin
                    send_word(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
                    i++;
                end
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SET_SIZE;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_req_type <= REQ_RESTART;
        s_query_value <= '0;
        m_ready <= 1'b0;
        for (int j = 0; j < MAX_PICK; j++)
            combo_pos[j] = POS_W'(j);
        combo_total = '0;
        size_error = 1'b0;
        set_n = '0;
        pick_k = '0;
        failures = 0;
        words_sent = 0;
        steady = 1'b0;
        ready_hold = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_pick();
        test_small_walk();
        test_bad_sizes();
        test_wide_pick();
        test_random_walks();

        settle();
        repeat (40) @(posedge aclk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
